// ===== hw/rtl/dfp_pkg.sv =====
// Shared types and constants of the delimited frame parser.
`default_nettype none
package dfp_pkg;

  localparam int TYPE_CAPACITY_DEF = 16;
  localparam int TEXT_CAPACITY_DEF = 64;

  localparam logic [7:0] START_BYTE_RST     = 8'h26;
  localparam logic [7:0] STOP_BYTE_RST      = 8'h24;
  localparam logic [7:0] SEPARATOR_BYTE_RST = 8'h3A;
  localparam logic [7:0] DIGIT_BASE         = 8'h30;

  localparam int POS_W = 6;

  typedef enum logic [1:0] {
    REG_START     = 2'd0,
    REG_STOP      = 2'd1,
    REG_SEPARATOR = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_WAIT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_SENDER  = 3'd2,
    PH_COMMAND = 3'd3,
    PH_MESSAGE = 3'd4,
    PH_ID      = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_IGNORED = 3'd0,
    EV_START   = 3'd1,
    EV_BYTE    = 3'd2,
    EV_END     = 3'd3,
    EV_ID      = 3'd4,
    EV_DONE    = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    FLD_TYPE    = 2'd0,
    FLD_SENDER  = 2'd1,
    FLD_COMMAND = 2'd2,
    FLD_MESSAGE = 2'd3
  } field_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] stop_byte;
    logic [7:0] separator_byte;
  } cfg_t;

  typedef struct packed {
    event_t           event_res;
    field_t           field;
    logic [POS_W-1:0] position;
    logic [7:0]       byte_value;
    logic [7:0]       ack_id;
    logic             frame_ready;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/dfp_core.sv =====
// Parser state registers and the per-byte next-state and event logic.
`default_nettype none
module dfp_core #(
  parameter int TYPE_CAPACITY = 16,
  parameter int TEXT_CAPACITY = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      rx_byte,
  input  wire dfp_pkg::cfg_t   cfg,
  output dfp_pkg::result_t     res
);
  import dfp_pkg::*;

  localparam int TW = $clog2(TYPE_CAPACITY);
  localparam int XW = $clog2(TEXT_CAPACITY);
  localparam logic [TW-1:0] TYPE_LAST = TW'(TYPE_CAPACITY - 1);
  localparam logic [XW-1:0] TEXT_LAST = XW'(TEXT_CAPACITY - 1);

  phase_t        phase, phase_next;
  logic [TW-1:0] type_count, type_count_next;
  logic [XW-1:0] sender_count, sender_count_next;
  logic [XW-1:0] command_count, command_count_next;
  logic [XW-1:0] message_count, message_count_next;
  logic [7:0]    frame_id, frame_id_next;
  logic          ready_flag, ready_flag_next;

  logic [TW-1:0] type_inc;
  logic [XW-1:0] sender_inc, command_inc, message_inc;
  logic          is_sep;

  // wrap at capacity
  assign type_inc    = (type_count == TYPE_LAST) ? '0 : type_count + TW'(1);
  assign sender_inc  = (sender_count == TEXT_LAST) ? '0 : sender_count + XW'(1);
  assign command_inc = (command_count == TEXT_LAST) ? '0 : command_count + XW'(1);
  assign message_inc = (message_count == TEXT_LAST) ? '0 : message_count + XW'(1);
  assign is_sep      = (rx_byte == cfg.separator_byte);

  always_comb begin
    phase_next         = phase;
    type_count_next    = type_count;
    sender_count_next  = sender_count;
    command_count_next = command_count;
    message_count_next = message_count;
    frame_id_next      = frame_id;
    ready_flag_next    = ready_flag;
    res.event_res      = EV_IGNORED;
    res.field          = FLD_TYPE;
    res.position       = '0;
    res.byte_value     = rx_byte;
    case (phase)
      PH_WAIT: begin
        if (rx_byte == cfg.start_byte) begin
          type_count_next    = '0;
          sender_count_next  = '0;
          command_count_next = '0;
          message_count_next = '0;
          ready_flag_next    = 1'b0;
          phase_next         = PH_TYPE;
          res.event_res      = EV_START;
        end
      end
      PH_TYPE: begin
        res.field    = FLD_TYPE;
        res.position = POS_W'(type_count);
        if (is_sep) begin
          res.event_res = EV_END;
          phase_next    = PH_SENDER;
        end else begin
          res.event_res   = EV_BYTE;
          type_count_next = type_inc;
        end
      end
      PH_SENDER: begin
        res.field    = FLD_SENDER;
        res.position = POS_W'(sender_count);
        if (is_sep) begin
          res.event_res = EV_END;
          phase_next    = PH_COMMAND;
        end else begin
          res.event_res     = EV_BYTE;
          sender_count_next = sender_inc;
        end
      end
      PH_COMMAND: begin
        res.field    = FLD_COMMAND;
        res.position = POS_W'(command_count);
        if (is_sep) begin
          res.event_res = EV_END;
          phase_next    = PH_MESSAGE;
        end else begin
          res.event_res      = EV_BYTE;
          command_count_next = command_inc;
        end
      end
      PH_MESSAGE: begin
        res.field    = FLD_MESSAGE;
        res.position = POS_W'(message_count);
        if (is_sep) begin
          res.event_res = EV_END;
          phase_next    = PH_ID;
        end else begin
          res.event_res      = EV_BYTE;
          message_count_next = message_inc;
        end
      end
      PH_ID: begin
        // stop check wins over separator
        if (rx_byte == cfg.stop_byte) begin
          ready_flag_next = 1'b1;
          phase_next      = PH_WAIT;
          res.event_res   = EV_DONE;
        end else begin
          frame_id_next = rx_byte - DIGIT_BASE;
          res.event_res = EV_ID;
        end
      end
      default: begin
        phase_next = PH_WAIT;
      end
    endcase
    res.ack_id      = frame_id_next;
    res.frame_ready = ready_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      type_count    <= '0;
      sender_count  <= '0;
      command_count <= '0;
      message_count <= '0;
      frame_id      <= '0;
      ready_flag    <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      type_count    <= type_count_next;
      sender_count  <= sender_count_next;
      command_count <= command_count_next;
      message_count <= message_count_next;
      frame_id      <= frame_id_next;
      ready_flag    <= ready_flag_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/delimited_frame_parser.sv =====
// Top level of the delimited frame parser: channels, config registers, pipeline.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   request. Every byte yields exactly one event request on the output
//   channel (out_valid/out_ready): event_res, field, position, byte_value,
//   ack_id and frame_ready. The parser keeps no text; the consumer fills
//   its own buffers from field/position/byte_value.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   start, stop and separator bytes; it is always ready. Write it only while
//   no byte is in flight.
// Timing:
//   Two stages: an input register holding the byte, then the parse logic
//   feeding the result register; a byte passes both before out_valid rises.
//   Throughput is one byte per cycle while out_ready does not stall the output;
//   dfp_core updates its state once per accepted byte.
// Reset:
//   Synchronous, active high. Both stages empty, parser waits for a start
//   byte, counts/id/ready flag cleared, config bytes back to 0x26/0x24/0x3A.
// Stall:
//   When out_ready is low a held result stays put; the input stage still
//   accepts one byte, then in_ready drops until the result is taken.
`default_nettype none
module delimited_frame_parser #(
  parameter int TYPE_CAPACITY = dfp_pkg::TYPE_CAPACITY_DEF,
  parameter int TEXT_CAPACITY = dfp_pkg::TEXT_CAPACITY_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // byte input
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  // event output
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      event_res,
  output logic [1:0]      field,
  output logic [5:0]      position,
  output logic [7:0]      byte_value,
  output logic [7:0]      ack_id,
  output logic            frame_ready,
  // config writes
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  import dfp_pkg::*;

  cfg_t       cfg;
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       advance;
  logic       step;
  result_t    res;
  result_t    out_res;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte     <= START_BYTE_RST;
      cfg.stop_byte      <= STOP_BYTE_RST;
      cfg.separator_byte <= SEPARATOR_BYTE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START:     cfg.start_byte     <= cfg_data;
        REG_STOP:      cfg.stop_byte      <= cfg_data;
        REG_SEPARATOR: cfg.separator_byte <= cfg_data;
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // result register moves when empty or being drained
  assign advance  = !out_valid || out_ready;
  assign step     = s1_valid && advance;
  assign in_ready = !s1_valid || advance;

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= rx_byte;
    end
  end

  dfp_core #(
    .TYPE_CAPACITY (TYPE_CAPACITY),
    .TEXT_CAPACITY (TEXT_CAPACITY)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (s1_byte),
    .cfg     (cfg),
    .res     (res)
  );

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign event_res   = out_res.event_res;
  assign field       = out_res.field;
  assign position    = out_res.position;
  assign byte_value  = out_res.byte_value;
  assign ack_id      = out_res.ack_id;
  assign frame_ready = out_res.frame_ready;

endmodule
`default_nettype wire
